>>> hdl/aepsc_pkg.sv
// shared constants and types for the array even/prime/sorted checker
package aepsc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

>>> hdl/aepsc_elem_if.sv
// valid/ready channel that carries one array element
interface aepsc_elem_if import aepsc_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

>>> hdl/aepsc_flags_if.sv
// valid/ready channel that carries the three array flags
interface aepsc_flags_if import aepsc_pkg::*; ();
    logic valid;
    logic ready;
    logic all_even;
    logic all_prime;
    logic nondecreasing;

    modport source (output valid, output all_even, output all_prime, output nondecreasing,
                    input ready);
    modport sink   (input valid, input all_even, input all_prime, input nondecreasing,
                    output ready);
endinterface

>>> hdl/array_even_prime_sorted_check.sv
// array checker: all even, all prime (trial division), nondecreasing
//
//  channel | role   | payload                              | transaction
//  --------+--------+--------------------------------------+---------------------------
//  elem    | sink   | value (signed), last                 | one array element
//  flags   | source | all_even, all_prime, nondecreasing   | one result per last element
//
// per element: one check step per trial divisor plus VALUE_BITS steps of the
// bit-serial remainder unit per divisor (179 divisors for the largest 16-bit prime);
// elements < 2 or after a non-prime skip the division.
// reset sets the running flags and clears the sequencer, no clearing pass.
// a pending result does not block the next element; a last element whose result
// cannot be loaded waits in the done state until flags.ready frees the slot.
module array_even_prime_sorted_check import aepsc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    aepsc_elem_if.sink    elem,
    aepsc_flags_if.source flags
);

    state_t state_reg, state_next;

    logic                         even_reg, even_next;
    logic                         prime_reg, prime_next;
    logic                         sorted_reg, sorted_next;
    logic                         first_reg, first_next;
    logic signed [VALUE_BITS-1:0] prev_reg, prev_next;
    logic                         last_reg, last_next;

    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [VALUE_BITS:0]   sq_reg, sq_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] sh_reg, sh_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    logic out_valid_reg, out_valid_next;
    logic out_even_reg, out_even_next;
    logic out_prime_reg, out_prime_next;
    logic out_sorted_reg, out_sorted_next;

    logic                  accept;
    logic                  load_out;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   trial_sub;
    logic [VALUE_BITS-1:0] rem_step;

    assign elem.ready          = (state_reg == ST_IDLE);
    assign accept              = elem.valid && elem.ready;
    assign flags.valid         = out_valid_reg;
    assign flags.all_even      = out_even_reg;
    assign flags.all_prime     = out_prime_reg;
    assign flags.nondecreasing = out_sorted_reg;

    // one restoring step of the remainder unit
    assign trial     = {rem_reg, sh_reg[VALUE_BITS-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign rem_step  = (trial >= {1'b0, div_reg}) ? trial_sub[VALUE_BITS-1:0]
                                                  : trial[VALUE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            even_reg      <= 1'b1;
            prime_reg     <= 1'b1;
            sorted_reg    <= 1'b1;
            first_reg     <= 1'b1;
            prev_reg      <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            even_reg      <= even_next;
            prime_reg     <= prime_next;
            sorted_reg    <= sorted_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        div_reg        <= div_next;
        sq_reg         <= sq_next;
        rem_reg        <= rem_next;
        sh_reg         <= sh_next;
        out_even_reg   <= out_even_next;
        out_prime_reg  <= out_prime_next;
        out_sorted_reg <= out_sorted_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        even_next       = even_reg;
        prime_next      = prime_reg;
        sorted_next     = sorted_reg;
        first_next      = first_reg;
        prev_next       = prev_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        div_next        = div_reg;
        sq_next         = sq_reg;
        rem_next        = rem_reg;
        sh_next         = sh_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        out_even_next   = out_even_reg;
        out_prime_next  = out_prime_reg;
        out_sorted_next = out_sorted_reg;
        load_out        = 1'b0;

        if (flags.valid && flags.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next  = elem.last;
                    n_next     = elem.value;
                    prev_next  = elem.value;
                    first_next = 1'b0;
                    if (elem.value[0])
                    begin
                        even_next = 1'b0;
                    end
                    if (!first_reg && (elem.value < prev_reg))
                    begin
                        sorted_next = 1'b0;
                    end
                    // negatives, zero and one are never prime
                    if (!prime_reg || (elem.value < $signed(VALUE_BITS'(2))))
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_next   = VALUE_BITS'(2);
                        sq_next    = (VALUE_BITS + 1)'(4);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    sh_next    = n_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_step;
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    if (rem_step == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {div_reg, 1'b0} + (VALUE_BITS + 1)'(1);
                        div_next   = div_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!flags.valid || flags.ready)
                begin
                    load_out        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_even_next   = even_reg;
                    out_prime_next  = prime_reg;
                    out_sorted_next = sorted_reg;
                    even_next       = 1'b1;
                    prime_next      = 1'b1;
                    sorted_next     = 1'b1;
                    first_next      = 1'b1;
                    prev_next       = '0;
                    last_next       = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // remainder stays below the trial divisor throughout the serial division
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> (div_reg >= VALUE_BITS'(2)) && (rem_reg < div_reg))
    else $error("remainder unit out of range");

    // a new result only comes from the done state of a last element
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE && last_reg))
    else $error("result raised outside done state");

    // after a result is loaded the running flags start a new array
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> even_reg && prime_reg && sorted_reg && first_reg && !last_reg)
    else $error("array state not cleared after result");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || flags.ready)
    else $error("result overwritten while pending");

endmodule
